/* rtl/pssc_pkg.sv */
// ----------------------------------------------------------------------------
// Poisson scan score engine package
// Shared widths, codes, constants and the log2 unit handshake types.
// ----------------------------------------------------------------------------
package pssc_pkg;

   localparam int DEF_MAX_ROWS      = 16;
   localparam int DEF_MAX_LOCATIONS = 64;
   localparam int DEF_MAX_ZONES     = 64;
   localparam int DEF_MAX_MEMBERS   = 256;

   localparam int OP_W     = 2;
   localparam int ROW_W    = 4;
   localparam int LOC_W    = 6;
   localparam int CNT_W    = 16;
   localparam int BASE_W   = 40;
   localparam int ZONE_W   = 7;
   localparam int DUR_W    = 5;
   localparam int SCORE_W  = 48;
   localparam int RR_W     = 32;
   localparam int STATUS_W = 2;

   // stored cumulative count, and zone sums sized for the largest member list
   localparam int CCNT_W    = 20;
   localparam int SUM_C_W   = 36;
   localparam int SUM_B_W   = 56;
   localparam int Q_FRAC_W  = 16;

   localparam int LOG_IN_W   = 56;
   localparam int LOG_INT_W  = 6;
   localparam int LOG_FRAC_W = 32;
   localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;

   localparam int LND_W   = LOG_W + 1;
   localparam int C_SPLIT = SUM_C_W / 2;
   localparam int PP_W    = C_SPLIT + LND_W;
   localparam int PROD_W  = SUM_C_W + LND_W;
   localparam int T_W     = PROD_W - Q_FRAC_W + 1;

   localparam logic [31:0] LN2_Q32 = 32'hB172_17F7;
   localparam logic [CCNT_W-1:0]  COUNT_MAX = '1;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [RR_W-1:0]    RR_MAX    = '1;
   localparam logic [RR_W-1:0]    RR_ONE    = 32'h0001_0000;

   localparam logic [OP_W-1:0] OP_CELL   = 2'd0;
   localparam logic [OP_W-1:0] OP_MEMBER = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_BASE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_ZONE   = 2'd2;

   typedef struct packed {
      logic                start;
      logic [LOG_IN_W-1:0] operand;
   } log_req_type;

   typedef struct packed {
      logic             done;
      logic [LOG_W-1:0] value;
   } log_rsp_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

/* rtl/pssc_log2.sv */
// ----------------------------------------------------------------------------
// Iterative log2 unit
// Q.32 log2 of a nonzero integer: normalize by shifting, then square the
// mantissa once per cycle to emit one fraction bit per cycle.
// ----------------------------------------------------------------------------
module pssc_log2 (
   input  logic                  clock,
   input  logic                  reset,
   input  pssc_pkg::log_req_type log_req,
   output pssc_pkg::log_rsp_type log_rsp
);
   import pssc_pkg::*;

   localparam int ITER_W = $clog2(LOG_FRAC_W);

   typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_type;

   lstate_type              state_ff;
   logic [LOG_IN_W-1:0]     x_ff;
   logic [LOG_INT_W-1:0]    n_ff;
   logic [LOG_FRAC_W-1:0]   m_ff;
   logic [LOG_FRAC_W-1:0]   frac_ff;
   logic [ITER_W-1:0]       iter_ff;
   logic                    done_ff;
   logic [LOG_W-1:0]        value_ff;

   logic [2*LOG_FRAC_W-1:0] square_in;
   logic [LOG_FRAC_W:0]     scaled_in;
   logic [LOG_FRAC_W-1:0]   m_in;
   logic [LOG_FRAC_W-1:0]   frac_in;

   assign square_in = (2*LOG_FRAC_W)'(m_ff) * (2*LOG_FRAC_W)'(m_ff);
   assign scaled_in = square_in[2*LOG_FRAC_W-1:LOG_FRAC_W-1];
   assign m_in      = scaled_in[LOG_FRAC_W] ? scaled_in[LOG_FRAC_W:1]
                                            : scaled_in[LOG_FRAC_W-1:0];
   assign frac_in   = {frac_ff[LOG_FRAC_W-2:0], scaled_in[LOG_FRAC_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == L_SQ) && (iter_ff == ITER_W'(LOG_FRAC_W - 1));
         case (state_ff)
            L_IDLE: begin
               if (log_req.start) begin
                  x_ff     <= log_req.operand;
                  n_ff     <= LOG_INT_W'(LOG_IN_W - 1);
                  state_ff <= L_NORM;
               end
            end
            L_NORM: begin
               // shift the top set bit up to the MSB, a byte at a time when possible
               if (x_ff[LOG_IN_W-1 -: 8] == 8'd0) begin
                  x_ff <= {x_ff[LOG_IN_W-9:0], 8'd0};
                  n_ff <= n_ff - LOG_INT_W'(8);
               end else if (!x_ff[LOG_IN_W-1]) begin
                  x_ff <= {x_ff[LOG_IN_W-2:0], 1'b0};
                  n_ff <= n_ff - LOG_INT_W'(1);
               end else begin
                  m_ff     <= x_ff[LOG_IN_W-1 -: LOG_FRAC_W];
                  frac_ff  <= '0;
                  iter_ff  <= '0;
                  state_ff <= L_SQ;
               end
            end
            L_SQ: begin
               m_ff    <= m_in;
               frac_ff <= frac_in;
               iter_ff <= iter_ff + ITER_W'(1);
               if (iter_ff == ITER_W'(LOG_FRAC_W - 1)) begin
                  value_ff <= {n_ff, frac_in};
                  state_ff <= L_IDLE;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign log_rsp.done  = done_ff;
   assign log_rsp.value = value_ff;

endmodule

/* rtl/poisson_scan_score_engine_top.sv */
// ----------------------------------------------------------------------------
// Poisson scan score engine
// Cell grid and zone lists in local memories; a query sums a zone at one
// duration and scores it with an iterative log2 unit and a restoring divider.
// ----------------------------------------------------------------------------
// Cell load: row 0 writes only; other rows first read the cell one row earlier.
// Zone member load: written as it is accepted. Query: accept, zone bounds, then a member
// read, a cell read and an accumulate per zone member, then checks, two log2 runs back
// to back on one unit, and multiply and compare; the divider runs alongside the logs.
// Unknown zone: answered from accept. Reset clears control, counters and the result
// channel; the stores are not cleared and need no clearing pass.
module poisson_scan_score_engine_top #(
   parameter int MAX_ROWS      = pssc_pkg::DEF_MAX_ROWS,
   parameter int MAX_LOCATIONS = pssc_pkg::DEF_MAX_LOCATIONS,
   parameter int MAX_ZONES     = pssc_pkg::DEF_MAX_ZONES,
   parameter int MAX_MEMBERS   = pssc_pkg::DEF_MAX_MEMBERS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pssc_pkg::OP_W-1:0]      req_operation,
   input  logic [pssc_pkg::ROW_W-1:0]     req_time_row,
   input  logic [pssc_pkg::LOC_W-1:0]     req_location,
   input  logic [pssc_pkg::CNT_W-1:0]     req_count,
   input  logic [pssc_pkg::BASE_W-1:0]    req_baseline,
   input  logic                           req_zone_last,
   input  logic [pssc_pkg::ZONE_W-1:0]    req_query_zone,
   input  logic [pssc_pkg::DUR_W-1:0]     req_query_duration,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pssc_pkg::ZONE_W-1:0]    rsp_zone_id,
   output logic [pssc_pkg::DUR_W-1:0]     rsp_duration_id,
   output logic [pssc_pkg::SCORE_W-1:0]   rsp_score,
   output logic [pssc_pkg::RR_W-1:0]      rsp_rel_risk,
   output logic [pssc_pkg::STATUS_W-1:0]  rsp_status
);
   import pssc_pkg::*;

   localparam int CELLS = MAX_ROWS * MAX_LOCATIONS;
   localparam int CAW   = addr_bits(CELLS);
   localparam int RAW   = addr_bits(MAX_ROWS);
   localparam int MAW   = addr_bits(MAX_MEMBERS);
   localparam int MTW   = $clog2(MAX_MEMBERS + 1);
   localparam int ZAW   = addr_bits(MAX_ZONES);
   localparam int ZTW   = $clog2(MAX_ZONES + 1);
   localparam int DCW   = $clog2(RR_W);

   typedef enum logic [4:0] {
      S_IDLE, S_CELL_RD, S_CELL_WR, S_ZEND, S_ZSTART, S_MRD, S_CRD, S_ACC,
      S_CHECK, S_LOGC_GO, S_LOGC_WAIT, S_LOGB_GO, S_LOGB_WAIT, S_LN, S_LN_SUM,
      S_MUL, S_PROD, S_T, S_SCORE, S_DONE
   } state_type;

   // storage
   logic [CCNT_W-1:0] count_mem  [CELLS];
   logic [BASE_W-1:0] base_mem   [CELLS];
   logic [LOC_W-1:0]  member_mem [MAX_MEMBERS];
   logic [MTW-1:0]    zend_mem   [MAX_ZONES];

   logic [CCNT_W-1:0] count_rd_ff;
   logic [BASE_W-1:0] base_rd_ff;
   logic [LOC_W-1:0]  member_rd_ff;
   logic [MTW-1:0]    zend_rd_ff;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [CAW-1:0]     cell_addr_ff;
   logic               first_row_ff;
   logic [ZONE_W-1:0]  qz_ff;
   logic [DUR_W-1:0]   qd_ff;
   logic [RAW-1:0]     row_ff;
   logic [MTW-1:0]     end_ff;
   logic [MTW-1:0]     k_ff;
   logic               use_ff;
   logic [SUM_C_W-1:0] c_ff;
   logic [SUM_B_W-1:0] b_ff;
   logic [LOG_W-1:0]   lc_ff;
   logic [LOG_W-1:0]   d_ff;
   logic [63:0]        lnlo_ff;
   logic [LOG_W-1:0]   lnhi_ff;
   logic [LND_W-1:0]   lnd_ff;
   logic [PP_W-1:0]    plo_ff;
   logic [PP_W-1:0]    phi_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [T_W-1:0]     t_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [RR_W-1:0]    rr_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [SUM_B_W-1:0] rem_ff;
   logic [RR_W-1:0]    quo_ff;
   logic [DCW-1:0]     dcnt_ff;
   logic               div_busy_ff;
   logic [MTW-1:0]     member_total_ff;
   logic [ZTW-1:0]     zone_total_ff;

   logic                rsp_valid_ff;
   logic [ZONE_W-1:0]   rsp_zone_id_ff;
   logic [DUR_W-1:0]    rsp_duration_id_ff;
   logic [SCORE_W-1:0]  rsp_score_ff;
   logic [RR_W-1:0]     rsp_rel_risk_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                accept;
   logic                member_we;
   logic                zend_we;
   logic                cell_we;
   logic [CCNT_W:0]     cell_sum_in;
   logic [CCNT_W-1:0]   cell_count_in;
   logic [CAW-1:0]      cell_raddr;
   logic [ZAW-1:0]      zend_raddr;
   logic [DUR_W-1:0]    qd_in;
   logic                zone_bad_in;
   logic [SUM_B_W-1:0]  cq_in;
   logic [T_W-1:0]      ct_in;
   logic [T_W-1:0]      diff_in;
   logic [SUM_B_W:0]    rem2_in;
   logic                ge_in;
   logic [SUM_B_W:0]    remsub_in;

   log_req_type log_req;
   log_rsp_type log_rsp;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign member_we = accept && (req_operation == OP_MEMBER)
                      && (int'(member_total_ff) < MAX_MEMBERS)
                      && (int'(zone_total_ff) < MAX_ZONES);
   assign zend_we   = member_we && req_zone_last;
   assign cell_we   = (state_ff == S_CELL_WR);

   assign cell_sum_in   = (CCNT_W+1)'(cnt_ff)
                          + (first_row_ff ? '0 : (CCNT_W+1)'(count_rd_ff));
   assign cell_count_in = cell_sum_in[CCNT_W] ? COUNT_MAX : cell_sum_in[CCNT_W-1:0];

   always_comb begin
      case (state_ff)
         S_CELL_RD: cell_raddr = cell_addr_ff - CAW'(MAX_LOCATIONS);
         default:   cell_raddr = CAW'(int'(row_ff) * MAX_LOCATIONS + int'(member_rd_ff));
      endcase
   end

   assign zend_raddr = (state_ff == S_IDLE) ? ZAW'(req_query_zone - ZONE_W'(1))
                                            : ZAW'(qz_ff - ZONE_W'(2));

   always_comb begin
      if (req_query_duration == '0) begin
         qd_in = DUR_W'(1);
      end else if (int'(req_query_duration) > MAX_ROWS) begin
         qd_in = DUR_W'(MAX_ROWS);
      end else begin
         qd_in = req_query_duration;
      end
   end

   assign zone_bad_in = (req_query_zone == '0)
                        || (int'(req_query_zone) > int'(zone_total_ff));

   assign cq_in   = SUM_B_W'({c_ff, {Q_FRAC_W{1'b0}}});
   assign ct_in   = T_W'(cq_in);
   assign diff_in = t_ff - ct_in;

   // restoring divider step
   assign rem2_in   = {rem_ff, 1'b0};
   assign ge_in     = (rem2_in >= {1'b0, b_ff});
   assign remsub_in = rem2_in - {1'b0, b_ff};

   assign log_req.start   = (state_ff == S_LOGC_GO) || (state_ff == S_LOGB_GO);
   assign log_req.operand = (state_ff == S_LOGC_GO) ? cq_in : b_ff;

   pssc_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .log_req (log_req),
      .log_rsp (log_rsp)
   );

   always_ff @(posedge clock) begin
      if (cell_we) begin
         count_mem[cell_addr_ff] <= cell_count_in;
         base_mem[cell_addr_ff]  <= base_ff;
      end
      count_rd_ff <= count_mem[cell_raddr];
      base_rd_ff  <= base_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (member_we) begin
         member_mem[member_total_ff[MAW-1:0]] <= req_location;
      end
      member_rd_ff <= member_mem[k_ff[MAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (zend_we) begin
         zend_mem[ZAW'(zone_total_ff)] <= member_total_ff + MTW'(1);
      end
      zend_rd_ff <= zend_mem[zend_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         div_busy_ff     <= 1'b0;
         member_total_ff <= '0;
         zone_total_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (member_we) begin
            member_total_ff <= member_total_ff + MTW'(1);
         end
         if (zend_we) begin
            zone_total_ff <= zone_total_ff + ZTW'(1);
         end

         if (div_busy_ff) begin
            rem_ff  <= ge_in ? remsub_in[SUM_B_W-1:0] : rem2_in[SUM_B_W-1:0];
            quo_ff  <= {quo_ff[RR_W-2:0], ge_in};
            dcnt_ff <= dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(RR_W - 1)) begin
               rr_ff       <= {quo_ff[RR_W-2:0], ge_in};
               div_busy_ff <= 1'b0;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cnt_ff       <= req_count;
                  base_ff      <= req_baseline;
                  cell_addr_ff <= CAW'(int'(req_time_row) * MAX_LOCATIONS
                                       + int'(req_location));
                  first_row_ff <= (req_time_row == '0);
                  qz_ff        <= req_query_zone;
                  qd_ff        <= qd_in;
                  row_ff       <= RAW'(qd_in - DUR_W'(1));
                  c_ff         <= '0;
                  b_ff         <= '0;
                  score_ff     <= '0;
                  rr_ff        <= RR_ONE;
                  status_ff    <= STATUS_OK;
                  case (req_operation)
                     OP_CELL: begin
                        if ((int'(req_time_row) < MAX_ROWS)
                            && (int'(req_location) < MAX_LOCATIONS)) begin
                           state_ff <= (req_time_row == '0) ? S_CELL_WR : S_CELL_RD;
                        end
                     end
                     OP_QUERY: begin
                        if (zone_bad_in) begin
                           status_ff <= STATUS_NO_ZONE;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_ZEND;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_CELL_RD: state_ff <= S_CELL_WR;
            S_CELL_WR: state_ff <= S_IDLE;
            S_ZEND: begin
               end_ff <= zend_rd_ff;
               if (qz_ff == ZONE_W'(1)) begin
                  k_ff     <= '0;
                  state_ff <= S_MRD;
               end else begin
                  state_ff <= S_ZSTART;
               end
            end
            S_ZSTART: begin
               k_ff     <= zend_rd_ff;
               state_ff <= S_MRD;
            end
            S_MRD: begin
               if (k_ff >= end_ff) begin
                  state_ff <= S_CHECK;
               end else begin
                  k_ff     <= k_ff + MTW'(1);
                  state_ff <= S_CRD;
               end
            end
            S_CRD: begin
               // members outside the grid add nothing
               use_ff   <= (int'(member_rd_ff) < MAX_LOCATIONS);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (use_ff) begin
                  c_ff <= c_ff + SUM_C_W'(count_rd_ff);
                  b_ff <= b_ff + SUM_B_W'(base_rd_ff);
               end
               state_ff <= S_MRD;
            end
            S_CHECK: begin
               if (b_ff == '0) begin
                  status_ff <= STATUS_ZERO_BASE;
                  if (c_ff != '0) begin
                     score_ff <= SCORE_MAX;
                     rr_ff    <= RR_MAX;
                  end
                  state_ff <= S_DONE;
               end else if (cq_in > b_ff) begin
                  if (SUM_B_W'(c_ff) >= b_ff) begin
                     rr_ff <= RR_MAX;
                  end else begin
                     rem_ff      <= SUM_B_W'(c_ff);
                     quo_ff      <= '0;
                     dcnt_ff     <= '0;
                     div_busy_ff <= 1'b1;
                  end
                  state_ff <= S_LOGC_GO;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_LOGC_GO: state_ff <= S_LOGC_WAIT;
            S_LOGC_WAIT: begin
               if (log_rsp.done) begin
                  lc_ff    <= log_rsp.value;
                  state_ff <= S_LOGB_GO;
               end
            end
            S_LOGB_GO: state_ff <= S_LOGB_WAIT;
            S_LOGB_WAIT: begin
               if (log_rsp.done) begin
                  d_ff     <= lc_ff - log_rsp.value;
                  state_ff <= S_LN;
               end
            end
            S_LN: begin
               lnlo_ff  <= 64'(d_ff[LOG_FRAC_W-1:0]) * 64'(LN2_Q32);
               lnhi_ff  <= LOG_W'(d_ff[LOG_W-1:LOG_FRAC_W]) * LOG_W'(LN2_Q32);
               state_ff <= S_LN_SUM;
            end
            S_LN_SUM: begin
               lnd_ff   <= LND_W'(lnhi_ff) + LND_W'(lnlo_ff[63:32]);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               plo_ff   <= PP_W'(c_ff[C_SPLIT-1:0]) * PP_W'(lnd_ff);
               phi_ff   <= PP_W'(c_ff[SUM_C_W-1:C_SPLIT]) * PP_W'(lnd_ff);
               state_ff <= S_PROD;
            end
            S_PROD: begin
               prod_ff  <= PROD_W'(plo_ff) + (PROD_W'(phi_ff) << C_SPLIT);
               state_ff <= S_T;
            end
            S_T: begin
               t_ff     <= T_W'(prod_ff[PROD_W-1:Q_FRAC_W]) + T_W'(b_ff);
               state_ff <= S_SCORE;
            end
            S_SCORE: begin
               // clamp at zero, saturate at the top
               if (t_ff <= ct_in) begin
                  score_ff <= '0;
               end else if (diff_in[T_W-1:SCORE_W] != '0) begin
                  score_ff <= SCORE_MAX;
               end else begin
                  score_ff <= diff_in[SCORE_W-1:0];
               end
               if (!div_busy_ff) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_zone_id_ff     <= qz_ff;
                  rsp_duration_id_ff <= qd_ff;
                  rsp_score_ff       <= score_ff;
                  rsp_rel_risk_ff    <= rr_ff;
                  rsp_status_ff      <= status_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_zone_id     = rsp_zone_id_ff;
   assign rsp_duration_id = rsp_duration_id_ff;
   assign rsp_score       = rsp_score_ff;
   assign rsp_rel_risk    = rsp_rel_risk_ff;
   assign rsp_status      = rsp_status_ff;

   a_no_zone_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NO_ZONE))
      |-> ((rsp_score == '0) && (rsp_rel_risk == RR_ONE)))
      else $error("unknown zone answered with a nonzero score");

   a_rr_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rel_risk >= RR_ONE))
      else $error("relative risk below one");

   a_member_bound: assert property (@(posedge clock) disable iff (reset)
      int'(member_total_ff) <= MAX_MEMBERS)
      else $error("member count past capacity");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation != OP_QUERY)) |=> !$rose(rsp_valid))
      else $error("load item produced a result");

endmodule

/* tb/poisson_scan_score_engine_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Poisson scan score engine testbench
// Loads a cell grid and zone lists, queries zones at directed and random durations and checks
// every answer against an in-bench score predictor, under sender idling and
// receiver stalls in several phases.
// ----------------------------------------------------------------------------
module poisson_scan_score_engine_top_tb;
   import pssc_pkg::*;

   localparam int ROWS = DEF_MAX_ROWS;
   localparam int LOCS = DEF_MAX_LOCATIONS;
   localparam int ZONES = DEF_MAX_ZONES;
   localparam int MEMBERS = DEF_MAX_MEMBERS;
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]   operation;
      logic [ROW_W-1:0]  time_row;
      logic [LOC_W-1:0]  location;
      logic [CNT_W-1:0]  count;
      logic [BASE_W-1:0] baseline;
      logic              zone_last;
      logic [ZONE_W-1:0] query_zone;
      logic [DUR_W-1:0]  query_duration;
   } scan_req_type;

   typedef struct {
      logic [ZONE_W-1:0]   zone_id;
      logic [DUR_W-1:0]    duration_id;
      logic [SCORE_W-1:0]  score;
      logic [RR_W-1:0]     rel_risk;
      logic [STATUS_W-1:0] status;
   } scan_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0]   req_operation = '0;
   logic [ROW_W-1:0]  req_time_row = '0;
   logic [LOC_W-1:0]  req_location = '0;
   logic [CNT_W-1:0]  req_count = '0;
   logic [BASE_W-1:0] req_baseline = '0;
   logic              req_zone_last = 1'b0;
   logic [ZONE_W-1:0] req_query_zone = '0;
   logic [DUR_W-1:0]  req_query_duration = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ZONE_W-1:0]   rsp_zone_id;
   logic [DUR_W-1:0]    rsp_duration_id;
   logic [SCORE_W-1:0]  rsp_score;
   logic [RR_W-1:0]     rsp_rel_risk;
   logic [STATUS_W-1:0] rsp_status;

   poisson_scan_score_engine_top DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [CCNT_W-1:0] cum_count [ROWS*LOCS];
   logic [BASE_W-1:0] cell_base [ROWS*LOCS];
   logic [LOC_W-1:0]  member_loc [MEMBERS];
   int                zone_stop [ZONES];
   int                members_held = 0;
   int                zones_closed = 0;

   scan_req_type pending_items [$];
   scan_rsp_type expected_answers [$];
   scan_req_type on_wire;
   int        items_total = 1;
   int        items_sent = 0;
   int        failures = 0;

   function automatic logic [63:0] log2_q32(input logic [63:0] x);
      int n;
      logic [63:0] m, frac;
      n = 63;
      frac = '0;
      while (!x[n]) n--;
      m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(n) << 32) | frac;
   endfunction

   task automatic apply_item(input scan_req_type it);
      logic [63:0] c, b, d2, lnd, t, cs;
      logic [127:0] wide;
      int dur, first, stop, idx;
      scan_rsp_type r;
      c = '0;
      b = '0;
      case (it.operation)
         OP_CELL: begin
            idx = int'(it.time_row) * LOCS + int'(it.location);
            t = 64'(it.count);
            if (it.time_row > 0) t += 64'(cum_count[idx - LOCS]);
            cum_count[idx] = (t > 64'(COUNT_MAX)) ? COUNT_MAX : t[CCNT_W-1:0];
            cell_base[idx] = it.baseline;
         end
         OP_MEMBER: begin
            if (members_held < MEMBERS && zones_closed < ZONES) begin
               member_loc[members_held] = it.location;
               members_held++;
               if (it.zone_last) begin
                  zone_stop[zones_closed] = members_held;
                  zones_closed++;
               end
            end
         end
         OP_QUERY: begin
            dur = int'(it.query_duration);
            if (dur == 0) dur = 1;
            if (dur > ROWS) dur = ROWS;
            r.zone_id = it.query_zone;
            r.duration_id = DUR_W'(dur);
            r.score = '0;
            r.rel_risk = RR_ONE;
            r.status = STATUS_OK;
            if (it.query_zone == 0 || int'(it.query_zone) > zones_closed) begin
               r.status = STATUS_NO_ZONE;
            end else begin
               first = (it.query_zone == 1) ? 0 : zone_stop[it.query_zone-2];
               stop = zone_stop[it.query_zone-1];
               for (int k = first; k < stop; k++) begin
                  idx = (dur - 1) * LOCS + int'(member_loc[k]);
                  c += 64'(cum_count[idx]);
                  b += 64'(cell_base[idx]);
               end
               cs = c << 16;
               if (b == 0) begin
                  r.status = STATUS_ZERO_BASE;
                  if (c > 0) begin
                     r.score = SCORE_MAX;
                     r.rel_risk = RR_MAX;
                  end
               end else if (cs > b) begin
                  d2 = log2_q32(cs) - log2_q32(b);
                  wide = 128'(d2) * 128'(LN2_Q32);
                  lnd = wide[95:32];
                  wide = 128'(c) * 128'(lnd);
                  t = wide[79:16] + b;
                  t = (t > cs) ? t - cs : 64'd0;
                  r.score = (t > 64'(SCORE_MAX)) ? SCORE_MAX : t[SCORE_W-1:0];
                  wide = (128'(c) << 32) / 128'(b);
                  r.rel_risk = (wide > 128'(RR_MAX)) ? RR_MAX : wide[RR_W-1:0];
               end
            end
            expected_answers.push_back(r);
         end
         default: ;
      endcase
   endtask

   function automatic int idle_phase();
      return (items_sent * 4) / items_total;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_item(on_wire);
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 &&
                $urandom_range(0, 99) >= (idle_phase() == 1 ? 75 :
                                          idle_phase() == 3 ? 16 : 0)) begin
               on_wire = pending_items.pop_front();
               req_valid <= 1'b1;
               req_operation <= on_wire.operation;
               req_time_row <= on_wire.time_row;
               req_location <= on_wire.location;
               req_count <= on_wire.count;
               req_baseline <= on_wire.baseline;
               req_zone_last <= on_wire.zone_last;
               req_query_zone <= on_wire.query_zone;
               req_query_duration <= on_wire.query_duration;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      scan_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected answer zone %0d duration %0d", rsp_zone_id,
                      rsp_duration_id);
               failures++;
            end else begin
               e = expected_answers.pop_front();
               if (rsp_zone_id !== e.zone_id) begin
                  $error("zone_id exp %0d got %0d", e.zone_id, rsp_zone_id);
                  failures++;
               end
               if (rsp_duration_id !== e.duration_id) begin
                  $error("duration_id exp %0d got %0d", e.duration_id, rsp_duration_id);
                  failures++;
               end
               if (rsp_score !== e.score) begin
                  $error("score exp %h got %h", e.score, rsp_score);
                  failures++;
               end
               if (rsp_rel_risk !== e.rel_risk) begin
                  $error("rel_risk exp %h got %h", e.rel_risk, rsp_rel_risk);
                  failures++;
               end
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status);
                  failures++;
               end
            end
         end
         rsp_ready <= $urandom_range(0, 99) >= (idle_phase() == 2 ? 75 :
                                                idle_phase() == 3 ? 16 : 0);
      end
   end

   function automatic scan_req_type noise_item(input logic [OP_W-1:0] op);
      scan_req_type it;
      it.operation = op;
      it.time_row = ROW_W'($urandom);
      it.location = LOC_W'($urandom);
      it.count = CNT_W'($urandom);
      it.baseline = BASE_W'({$urandom, $urandom});
      it.zone_last = 1'($urandom);
      it.query_zone = ZONE_W'($urandom);
      it.query_duration = DUR_W'($urandom);
      return it;
   endfunction

   // the sixteen locations that zones draw from: all location bits toggle
   function automatic logic [LOC_W-1:0] zone_loc(input int k);
      return LOC_W'((k < 8) ? k : 48 + k);
   endfunction

   task automatic add_cell(input int row, input int loc, input logic [CNT_W-1:0] cnt,
                           input logic [BASE_W-1:0] base);
      scan_req_type it;
      it = noise_item(OP_CELL);
      it.time_row = ROW_W'(row);
      it.location = LOC_W'(loc);
      it.count = cnt;
      it.baseline = base;
      pending_items.push_back(it);
   endtask

   task automatic add_member(input int loc, input logic last);
      scan_req_type it;
      it = noise_item(OP_MEMBER);
      it.location = LOC_W'(loc);
      it.zone_last = last;
      pending_items.push_back(it);
   endtask

   task automatic add_query(input int zone, input int dur);
      scan_req_type it;
      it = noise_item(OP_QUERY);
      it.query_zone = ZONE_W'(zone);
      it.query_duration = DUR_W'(dur);
      pending_items.push_back(it);
   endtask

   function automatic logic [BASE_W-1:0] rand_base();
      logic [63:0] v;
      v = {$urandom, $urandom};
      v = v >> $urandom_range(24, 63);
      return v[BASE_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] rand_count();
      return CNT_W'($urandom_range(0, 65535) >> $urandom_range(0, 16));
   endfunction

   initial begin
      int pick;
      // fill every row of the zone locations, oldest dependency first
      for (int r = 0; r < ROWS; r++)
         for (int k = 0; k < 16; k++)
            add_cell(r, zone_loc(k), rand_count(), rand_base());
      // directed: no zones yet, zero baselines, extremes, range clamps
      add_query(1, 1);
      add_cell(0, 5, 16'd7, '0);
      add_cell(0, 6, '0, '0);
      add_cell(15, 63, 16'hFFFF, '1);
      add_cell(0, 0, '0, 40'd1);
      add_cell(0, 63, 16'hFFFF, '0);
      add_member(5, 1'b1);
      add_member(6, 1'b1);
      add_member(0, 1'b0);
      add_member(63, 1'b1);
      add_query(1, 1);
      add_query(2, 1);
      add_query(3, 1);
      add_query(3, 0);
      add_query(3, 31);
      add_query(3, 16);
      add_query(0, 4);
      add_query(4, 2);
      add_query(127, 8);
      pending_items.push_back(noise_item(OP_IGNORED));
      for (int i = 0; i < 620; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            add_cell($urandom_range(0, ROWS-1), zone_loc($urandom_range(0, 15)),
                     rand_count(), rand_base());
         end else if (pick < 36) begin
            add_cell(0, $urandom_range(0, LOCS-1), CNT_W'($urandom),
                     BASE_W'({$urandom, $urandom}));
         end else if (pick < 66) begin
            add_member(zone_loc($urandom_range(0, 15)), $urandom_range(0, 3) == 0);
         end else if (pick < 95) begin
            add_query(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 66),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(1, 16));
         end else begin
            pending_items.push_back(noise_item(OP_IGNORED));
         end
      end
      items_total = pending_items.size();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (pending_items.size() > 0 || req_valid);
      do @(posedge clock); while (expected_answers.size() > 0);
      repeat (400) @(posedge clock);
      if (failures == 0 && expected_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
rtl/pssc_pkg.sv
rtl/pssc_log2.sv
rtl/poisson_scan_score_engine_top.sv
tb/poisson_scan_score_engine_top_tb.sv
